// File: sv/tsr_pkg.sv
package tsr_pkg;

    // Default sizes of the slot table and of the host set.
    localparam int SLOTS_DEF = 64;
    localparam int HOSTS_DEF = 4;

    // Depth of the queue between the front and the back.
    localparam int QDEPTH = 2;
    localparam int QPTR_W = 1;
    localparam int QCNT_W = 2;

    // Event codes and values with a meaning of their own.
    localparam logic [15:0] TYPE_ABS      = 16'h0003;
    localparam logic [15:0] CODE_WINDOW   = 16'h0028;
    localparam logic [15:0] CODE_SLOT     = 16'h002f;
    localparam logic [15:0] CODE_TRACK_ID = 16'h0039;
    localparam logic signed [31:0] VALUE_RELEASE = -32'sd1;

    // Width of the host index carried in a request.
    localparam int HOST_W = 2;

    // A slot table entry holds the host and the host slot.
    localparam int ENTRY_W = HOST_W + 32;

    typedef struct packed {
        logic [HOST_W-1:0]  src_host;
        logic               is_touch_device;
        logic [15:0]        ev_type;
        logic [15:0]        ev_code;
        logic signed [31:0] ev_value;
    } req_t;

    typedef struct packed {
        logic [15:0]        out_type;
        logic [15:0]        out_code;
        logic signed [31:0] out_value;
        logic               out_last;
        logic               table_full;
    } res_t;

    // A request after classification by the front.
    typedef struct packed {
        req_t req;
        logic pass;
        logic is_slot;
        logic is_win;
        logic is_track;
    } item_t;

endpackage

// File: sv/tsr_front.sv
module tsr_front #(
    parameter int HOSTS = tsr_pkg::HOSTS_DEF
) (
    input  logic           start,
    input  tsr_pkg::req_t  req,
    input  logic           q_full,
    output logic           busy,
    output logic           push,
    output tsr_pkg::item_t item
);

    // A request is taken whenever the queue has room.
    assign busy = q_full;
    assign push = start && !q_full;

    // Classify the request: only absolute-axis touch events of a known host
    // go through the slot translation.
    always_comb
    begin
        item.req      = req;
        item.pass     = (req.ev_type != tsr_pkg::TYPE_ABS) || !req.is_touch_device
                        || (32'(req.src_host) >= HOSTS);
        item.is_slot  = (req.ev_code == tsr_pkg::CODE_SLOT);
        item.is_win   = (req.ev_code == tsr_pkg::CODE_WINDOW);
        item.is_track = (req.ev_code == tsr_pkg::CODE_TRACK_ID);
    end

endmodule

// File: sv/tsr_queue.sv
module tsr_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  tsr_pkg::item_t push_item,
    input  logic           pop,
    output tsr_pkg::item_t head,
    output logic           empty,
    output logic           full
);

    tsr_pkg::item_t entry_reg [tsr_pkg::QDEPTH];
    logic [tsr_pkg::QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [tsr_pkg::QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [tsr_pkg::QCNT_W-1:0] count_reg, count_next;

    assign empty = (count_reg == '0);
    assign full  = (count_reg == tsr_pkg::QCNT_W'(tsr_pkg::QDEPTH));
    assign head  = entry_reg[rd_ptr_reg];

    // Pointer and fill count update.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

// File: sv/tsr_back.sv
module tsr_back #(
    parameter int SLOTS = tsr_pkg::SLOTS_DEF,
    parameter int HOSTS = tsr_pkg::HOSTS_DEF
) (
    input  logic           clk,
    input  logic           rst_n,
    input  tsr_pkg::item_t head,
    input  logic           empty,
    output logic           pop,
    output logic           res_valid,
    output tsr_pkg::res_t  res
);

    localparam int SIDX_W = $clog2(SLOTS);
    localparam int HIDX_W = (HOSTS > 1) ? $clog2(HOSTS) : 1;
    localparam logic [SIDX_W-1:0] LAST_IDX = SIDX_W'(SLOTS - 1);

    localparam logic [2:0] ST_IDLE      = 3'd0;
    localparam logic [2:0] ST_SCAN      = 3'd1;
    localparam logic [2:0] ST_DECIDE    = 3'd2;
    localparam logic [2:0] ST_EMIT_WIN  = 3'd3;
    localparam logic [2:0] ST_EMIT_SLOT = 3'd4;
    localparam logic [2:0] ST_EMIT_EVT  = 3'd5;

    logic [2:0] state_reg, state_next;

    // Request under work and its derived values.
    tsr_pkg::item_t work_reg, work_next;
    logic [31:0]        hslot_reg, hslot_next;
    logic signed [31:0] value_reg, value_next;
    logic               full_reg, full_next;
    logic [31:0]        win_reg, win_next;
    logic               need_slot_reg, need_slot_next;
    logic [SIDX_W-1:0]  slot_reg, slot_next;

    // Scan control.
    logic [SIDX_W-1:0]  addr_reg, addr_next;
    logic               issue_reg, issue_next;
    logic               chk_valid_reg, chk_valid_next;
    logic [SIDX_W-1:0]  chk_idx_reg, chk_idx_next;
    logic               have_free_reg, have_free_next;
    logic [SIDX_W-1:0]  free_idx_reg, free_idx_next;

    // Slot table: valid bits in flops, host and host slot in memory.
    logic [SLOTS-1:0]   valid_reg, valid_next;
    logic [tsr_pkg::ENTRY_W-1:0] slot_mem [SLOTS];
    logic [tsr_pkg::ENTRY_W-1:0] rd_data_reg;
    logic               mem_we;
    logic [SIDX_W-1:0]  mem_waddr;

    // Per-host and global state.
    logic [31:0] host_cur_slot_reg [HOSTS];
    logic [31:0] host_cur_slot_next [HOSTS];
    logic [31:0] host_window_reg [HOSTS];
    logic [31:0] host_window_next [HOSTS];
    logic [31:0]       cur_window_reg, cur_window_next;
    logic [SIDX_W-1:0] cur_slot_reg, cur_slot_next;
    logic [15:0]       track_reg, track_next;

    // Result register.
    tsr_pkg::res_t res_reg, res_next;
    logic          res_valid_reg, res_valid_next;

    logic [HIDX_W-1:0] head_ix;
    logic [HIDX_W-1:0] work_ix;
    logic              hit;
    logic [31:0]       win;
    logic              slot_diff;

    assign head_ix   = HIDX_W'(head.req.src_host);
    assign work_ix   = HIDX_W'(work_reg.req.src_host);
    assign pop       = (state_reg == ST_IDLE) && !empty;
    assign res       = res_reg;
    assign res_valid = res_valid_reg;

    // Comparison of the entry read back against the request.
    assign hit = chk_valid_reg && valid_reg[chk_idx_reg]
                 && (rd_data_reg[tsr_pkg::ENTRY_W-1:32] == work_reg.req.src_host)
                 && (rd_data_reg[31:0] == hslot_reg);

    // Window and slot decisions for the decide step.
    assign win = work_reg.is_win ? 32'(work_reg.req.ev_value) : host_window_reg[work_ix];
    assign slot_diff = (slot_reg != cur_slot_reg);

    // Sequencer of the back part.
    always_comb
    begin
        state_next         = state_reg;
        work_next          = work_reg;
        hslot_next         = hslot_reg;
        value_next         = value_reg;
        full_next          = full_reg;
        win_next           = win_reg;
        need_slot_next     = need_slot_reg;
        slot_next          = slot_reg;
        addr_next          = addr_reg;
        issue_next         = issue_reg;
        chk_valid_next     = chk_valid_reg;
        chk_idx_next       = chk_idx_reg;
        have_free_next     = have_free_reg;
        free_idx_next      = free_idx_reg;
        valid_next         = valid_reg;
        host_cur_slot_next = host_cur_slot_reg;
        host_window_next   = host_window_reg;
        cur_window_next    = cur_window_reg;
        cur_slot_next      = cur_slot_reg;
        track_next         = track_reg;
        res_next           = res_reg;
        res_valid_next     = 1'b0;
        mem_we             = 1'b0;
        mem_waddr          = free_idx_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (!empty)
                begin
                    work_next  = head;
                    value_next = head.req.ev_value;
                    full_next  = 1'b0;
                    if (head.pass)
                    begin
                        state_next = ST_EMIT_EVT;
                    end
                    else
                    begin
                        hslot_next = head.is_slot ? 32'(head.req.ev_value)
                                                  : host_cur_slot_reg[head_ix];
                        host_cur_slot_next[head_ix] = hslot_next;
                        addr_next      = '0;
                        issue_next     = 1'b1;
                        chk_valid_next = 1'b0;
                        have_free_next = 1'b0;
                        state_next     = ST_SCAN;
                    end
                end
            end

            ST_SCAN:
            begin
                // Issue one table read per cycle.
                chk_valid_next = issue_reg;
                chk_idx_next   = addr_reg;
                if (issue_reg)
                begin
                    if (addr_reg == LAST_IDX)
                    begin
                        issue_next = 1'b0;
                    end
                    else
                    begin
                        addr_next = addr_reg + 1'b1;
                    end
                end
                // Check the entry that came back.
                if (hit)
                begin
                    slot_next      = chk_idx_reg;
                    issue_next     = 1'b0;
                    chk_valid_next = 1'b0;
                    state_next     = ST_DECIDE;
                end
                else if (chk_valid_reg)
                begin
                    if (!have_free_reg && !valid_reg[chk_idx_reg])
                    begin
                        have_free_next = 1'b1;
                        free_idx_next  = chk_idx_reg;
                    end
                    if (chk_idx_reg == LAST_IDX)
                    begin
                        chk_valid_next = 1'b0;
                        if (have_free_next)
                        begin
                            // Claim the first free entry.
                            mem_we                 = 1'b1;
                            mem_waddr              = free_idx_next;
                            valid_next[free_idx_next] = 1'b1;
                            slot_next              = free_idx_next;
                            state_next             = ST_DECIDE;
                        end
                        else
                        begin
                            // Table is full: the event goes out untranslated.
                            full_next  = 1'b1;
                            state_next = ST_EMIT_EVT;
                        end
                    end
                end
            end

            ST_DECIDE:
            begin
                if (work_reg.is_win)
                begin
                    host_window_next[work_ix] = 32'(work_reg.req.ev_value);
                end
                win_next        = win;
                cur_window_next = win;
                cur_slot_next   = slot_reg;
                need_slot_next  = slot_diff && !work_reg.is_slot;
                if (slot_diff && work_reg.is_slot)
                begin
                    value_next = 32'(slot_reg);
                end
                // Tracking id: release frees the entry, others get the counter.
                if (work_reg.is_track)
                begin
                    if (work_reg.req.ev_value == tsr_pkg::VALUE_RELEASE)
                    begin
                        valid_next[slot_reg] = 1'b0;
                    end
                    else
                    begin
                        value_next = 32'(track_reg);
                        track_next = track_reg + 1'b1;
                    end
                end
                if ((win != cur_window_reg) && !work_reg.is_win)
                begin
                    state_next = ST_EMIT_WIN;
                end
                else if (need_slot_next)
                begin
                    state_next = ST_EMIT_SLOT;
                end
                else
                begin
                    state_next = ST_EMIT_EVT;
                end
            end

            ST_EMIT_WIN:
            begin
                res_valid_next      = 1'b1;
                res_next.out_type   = tsr_pkg::TYPE_ABS;
                res_next.out_code   = tsr_pkg::CODE_WINDOW;
                res_next.out_value  = win_reg;
                res_next.out_last   = 1'b0;
                res_next.table_full = 1'b0;
                state_next = need_slot_reg ? ST_EMIT_SLOT : ST_EMIT_EVT;
            end

            ST_EMIT_SLOT:
            begin
                res_valid_next      = 1'b1;
                res_next.out_type   = tsr_pkg::TYPE_ABS;
                res_next.out_code   = tsr_pkg::CODE_SLOT;
                res_next.out_value  = 32'(slot_reg);
                res_next.out_last   = 1'b0;
                res_next.table_full = 1'b0;
                state_next = ST_EMIT_EVT;
            end

            ST_EMIT_EVT:
            begin
                res_valid_next      = 1'b1;
                res_next.out_type   = work_reg.req.ev_type;
                res_next.out_code   = work_reg.req.ev_code;
                res_next.out_value  = value_reg;
                res_next.out_last   = 1'b1;
                res_next.table_full = full_reg;
                state_next = ST_IDLE;
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            issue_reg      <= 1'b0;
            chk_valid_reg  <= 1'b0;
            have_free_reg  <= 1'b0;
            valid_reg      <= '0;
            cur_window_reg <= '0;
            cur_slot_reg   <= '0;
            track_reg      <= '0;
            res_valid_reg  <= 1'b0;
            for (int h = 0; h < HOSTS; h++)
            begin
                host_cur_slot_reg[h] <= '0;
                host_window_reg[h]   <= '0;
            end
        end
        else
        begin
            state_reg         <= state_next;
            issue_reg         <= issue_next;
            chk_valid_reg     <= chk_valid_next;
            have_free_reg     <= have_free_next;
            valid_reg         <= valid_next;
            cur_window_reg    <= cur_window_next;
            cur_slot_reg      <= cur_slot_next;
            track_reg         <= track_next;
            res_valid_reg     <= res_valid_next;
            host_cur_slot_reg <= host_cur_slot_next;
            host_window_reg   <= host_window_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        work_reg      <= work_next;
        hslot_reg     <= hslot_next;
        value_reg     <= value_next;
        full_reg      <= full_next;
        win_reg       <= win_next;
        need_slot_reg <= need_slot_next;
        slot_reg      <= slot_next;
        addr_reg      <= addr_next;
        chk_idx_reg   <= chk_idx_next;
        free_idx_reg  <= free_idx_next;
        res_reg       <= res_next;
    end

    // Slot table memory: one write port, one registered read port.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            slot_mem[mem_waddr] <= {work_reg.req.src_host, hslot_reg};
        end
        rd_data_reg <= slot_mem[addr_reg];
    end

endmodule

// File: sv/touch_slot_remapper_unit.sv
// A request that scans the whole slot table reads one entry per cycle, and a hit ends the
// scan early. The back part takes one request at a time from idle through scan, decide and the
// emit states; one that bypasses translation goes from idle straight to emitting its event.
// A two-entry queue takes new requests meanwhile. Reset (rst_n, asynchronous) empties the queue
// and invalidates every slot entry; results show for one cycle and the receiver cannot stall.
module touch_slot_remapper_unit #(
    parameter int SLOTS = tsr_pkg::SLOTS_DEF,
    parameter int HOSTS = tsr_pkg::HOSTS_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  tsr_pkg::req_t req,
    output logic          busy,
    output logic          res_valid,
    output tsr_pkg::res_t res
);

    tsr_pkg::item_t push_item;
    tsr_pkg::item_t head;
    logic           push;
    logic           pop;
    logic           q_empty;
    logic           q_full;

    tsr_front #(
        .HOSTS (HOSTS)
    ) u_front (
        .start  (start),
        .req    (req),
        .q_full (q_full),
        .busy   (busy),
        .push   (push),
        .item   (push_item)
    );

    tsr_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .pop       (pop),
        .head      (head),
        .empty     (q_empty),
        .full      (q_full)
    );

    tsr_back #(
        .SLOTS (SLOTS),
        .HOSTS (HOSTS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head      (head),
        .empty     (q_empty),
        .pop       (pop),
        .res_valid (res_valid),
        .res       (res)
    );

endmodule

// File: dv/touch_slot_remapper_unit_tb.sv
module touch_slot_remapper_unit_tb;

    localparam int SLOTS = tsr_pkg::SLOTS_DEF;
    localparam int HOSTS = tsr_pkg::HOSTS_DEF;

    // Far above a run in which every request scans the full table after the longest gap.
    localparam longint TIMEOUT_TIME = 64'd400_000;

    // Ordinary event codes used as payload traffic.
    localparam logic [15:0] TYPE_KEY      = 16'h0001;
    localparam logic [15:0] CODE_POS_X    = 16'h0035;
    localparam logic [15:0] CODE_POS_Y    = 16'h0036;
    localparam logic [15:0] CODE_PRESSURE = 16'h003a;

    logic           clk;
    logic           rst_n;
    logic           start;
    tsr_pkg::req_t  req;
    logic           busy;
    logic           res_valid;
    tsr_pkg::res_t  res;

    touch_slot_remapper_unit u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .req       (req),
        .busy      (busy),
        .res_valid (res_valid),
        .res       (res)
    );

    // Mirror of the remapper state.
    logic                       slot_used   [SLOTS];
    logic [tsr_pkg::HOST_W-1:0] slot_owner  [SLOTS];
    logic [31:0]                slot_hslot  [SLOTS];
    logic [31:0]                host_slot_now [HOSTS];
    logic [31:0]                host_win    [HOSTS];
    logic [31:0]                win_now;
    int                         out_slot_now;
    logic [15:0]                track_next;

    // Output events still owed by the block, oldest first.
    tsr_pkg::res_t pending_events[$];

    int n_items;
    int n_results;
    int n_full;
    int n_inserted;
    int n_errors;
    bit burst_mode;

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        #(TIMEOUT_TIME);
        $display("Some tests failed");
        $finish;
    end

    function automatic tsr_pkg::req_t make_req(input logic [tsr_pkg::HOST_W-1:0] host,
                                               input logic touch,
                                               input logic [15:0] ev_type,
                                               input logic [15:0] code,
                                               input logic [31:0] value);
        tsr_pkg::req_t r;
        r.src_host        = host;
        r.is_touch_device = touch;
        r.ev_type         = ev_type;
        r.ev_code         = code;
        r.ev_value        = value;
        return r;
    endfunction

    function automatic tsr_pkg::req_t abs_event(input logic [tsr_pkg::HOST_W-1:0] host,
                                                input logic [15:0] code,
                                                input logic [31:0] value);
        return make_req(host, 1'b1, tsr_pkg::TYPE_ABS, code, value);
    endfunction

    function automatic int next_gap();
        return burst_mode ? 0 : $urandom_range(0, 15);
    endfunction

    // Finds the output slot of (host, host slot), claiming the first free entry on a miss.
    function automatic bit claim_slot(input logic [tsr_pkg::HOST_W-1:0] host,
                                      input logic [31:0] hslot, output int idx);
        int free_idx;
        free_idx = -1;
        idx = 0;
        host_slot_now[host] = hslot;
        for (int i = 0; i < SLOTS; i++)
        begin
            if (slot_used[i] && slot_owner[i] == host && slot_hslot[i] == hslot)
            begin
                idx = i;
                return 1'b1;
            end
            if (free_idx < 0 && !slot_used[i])
                free_idx = i;
        end
        if (free_idx < 0)
            return 1'b0;
        slot_used[free_idx]  = 1'b1;
        slot_owner[free_idx] = host;
        slot_hslot[free_idx] = hslot;
        idx = free_idx;
        return 1'b1;
    endfunction

    // Works out the output events of one accepted request and queues them.
    task automatic remap_event(input tsr_pkg::req_t r);
        tsr_pkg::res_t outs[3];
        int            n;
        int            idx;
        bit            ok;
        logic [31:0]   win;
        logic [31:0]   value;
        n = 0;
        value = r.ev_value;
        if (r.ev_type != tsr_pkg::TYPE_ABS || !r.is_touch_device || int'(r.src_host) >= HOSTS)
        begin
            outs[0] = '{r.ev_type, r.ev_code, value, 1'b0, 1'b0};
            n = 1;
        end
        else
        begin
            if (r.ev_code == tsr_pkg::CODE_SLOT)
                ok = claim_slot(r.src_host, value, idx);
            else
                ok = claim_slot(r.src_host, host_slot_now[r.src_host], idx);

            if (!ok)
            begin
                // No slot could be found: the event goes out untranslated and flagged.
                outs[0] = '{r.ev_type, r.ev_code, value, 1'b0, 1'b1};
                n = 1;
                n_full++;
            end
            else
            begin
                win = host_win[r.src_host];
                if (r.ev_code == tsr_pkg::CODE_WINDOW)
                begin
                    win = value;
                    host_win[r.src_host] = win;
                end

                // A window change is announced ahead of the event.
                if (win != win_now)
                begin
                    if (r.ev_code != tsr_pkg::CODE_WINDOW)
                    begin
                        outs[n] = '{tsr_pkg::TYPE_ABS, tsr_pkg::CODE_WINDOW, win, 1'b0, 1'b0};
                        n++;
                        n_inserted++;
                    end
                    win_now = win;
                end

                // A slot change rewrites a slot event or inserts one.
                if (idx != out_slot_now)
                begin
                    if (r.ev_code == tsr_pkg::CODE_SLOT)
                        value = 32'(idx);
                    else
                    begin
                        outs[n] = '{tsr_pkg::TYPE_ABS, tsr_pkg::CODE_SLOT, 32'(idx),
                                    1'b0, 1'b0};
                        n++;
                        n_inserted++;
                    end
                    out_slot_now = idx;
                end

                // Tracking ids either free the slot or take the running counter.
                if (r.ev_code == tsr_pkg::CODE_TRACK_ID)
                begin
                    if ($signed(value) == tsr_pkg::VALUE_RELEASE)
                        slot_used[idx] = 1'b0;
                    else
                    begin
                        value = {16'h0000, track_next};
                        track_next = track_next + 16'd1;
                    end
                end

                outs[n] = '{r.ev_type, r.ev_code, value, 1'b0, 1'b0};
                n++;
            end
        end
        outs[n-1].out_last = 1'b1;
        for (int i = 0; i < n; i++)
            pending_events.push_back(outs[i]);
    endtask

    // Sends one request after an idle gap and records what it should produce.
    task automatic issue_event(input tsr_pkg::req_t r, input int gap);
        repeat (gap)
        begin
            @(negedge clk);
            start <= 1'b0;
        end
        @(negedge clk);
        start <= 1'b1;
        req   <= r;
        do
            @(posedge clk);
        while (busy);
        remap_event(r);
        n_items++;
    endtask

    // Holds requests back until every owed event has come out.
    task automatic wait_idle();
        @(negedge clk);
        start <= 1'b0;
        while (pending_events.size() != 0)
            @(posedge clk);
    endtask

    // Each output event is checked against the oldest owed event.
    always @(posedge clk)
    begin
        tsr_pkg::res_t want;
        logic          bad;
        if (rst_n && res_valid)
        begin
            n_results++;
            if (pending_events.size() == 0)
            begin
                n_errors++;
                if (n_errors <= 10)
                    $display("unexpected event: type %h code %h value %h last %b full %b",
                             res.out_type, res.out_code, res.out_value, res.out_last,
                             res.table_full);
            end
            else
            begin
                want = pending_events.pop_front();
                bad = (res.out_type !== want.out_type) || (res.out_code !== want.out_code) ||
                      (res.out_value !== want.out_value) || (res.out_last !== want.out_last) ||
                      (res.table_full !== want.table_full);
                if (bad)
                begin
                    n_errors++;
                    if (n_errors <= 10)
                        $display("mismatch: got type %h code %h value %h last %b full %b, %s",
                                 res.out_type, res.out_code, res.out_value, res.out_last,
                                 res.table_full,
                                 $sformatf("wanted type %h code %h value %h last %b full %b",
                                           want.out_type, want.out_code, want.out_value,
                                           want.out_last, want.table_full));
                end
            end
        end
    end

    // Events outside the touch axis path must come out as they went in.
    task automatic test_passthrough();
        issue_event(make_req(2'd0, 1'b1, TYPE_KEY, 16'h0110, 32'h0000_0001), next_gap());
        issue_event(make_req(2'd3, 1'b0, tsr_pkg::TYPE_ABS, tsr_pkg::CODE_SLOT,
                             32'h0000_0005), next_gap());
        issue_event(make_req(2'd2, 1'b1, 16'hFFFF, 16'hFFFF, 32'h8000_0000), next_gap());
        issue_event(make_req(2'd1, 1'b0, 16'h0000, 16'h0000, 32'h7FFF_FFFF), next_gap());
        issue_event(make_req(2'd3, 1'b1, 16'h0002, tsr_pkg::CODE_TRACK_ID, 32'hFFFF_FFFF),
                    next_gap());
        issue_event(make_req(2'd1, 1'b0, tsr_pkg::TYPE_ABS, tsr_pkg::CODE_TRACK_ID,
                             32'h0000_0000), next_gap());
    endtask

    // Back to back tracking ids on one slot take consecutive counter values.
    task automatic test_track_counter();
        logic [31:0] value;
        burst_mode = 1'b1;
        for (int i = 0; i < 12; i++)
        begin
            value = $urandom;
            if (value == 32'hFFFF_FFFF)
                value = 32'h0000_0000;
            issue_event(abs_event(2'd0, tsr_pkg::CODE_TRACK_ID, value), 0);
        end
        burst_mode = 1'b0;
        wait_idle();
    endtask

    // Window and slot changes, rewritten slot events, releases and value extremes.
    task automatic test_window_slot();
        issue_event(abs_event(2'd1, tsr_pkg::CODE_WINDOW, 32'd7), next_gap());
        issue_event(abs_event(2'd2, CODE_POS_X, 32'd100), next_gap());
        issue_event(abs_event(2'd1, tsr_pkg::CODE_SLOT, 32'd3), next_gap());
        issue_event(abs_event(2'd1, tsr_pkg::CODE_TRACK_ID, 32'd42), next_gap());
        issue_event(abs_event(2'd1, tsr_pkg::CODE_TRACK_ID, 32'hFFFF_FFFF), next_gap());
        issue_event(abs_event(2'd0, tsr_pkg::CODE_SLOT, 32'hFFFF_FFFF), next_gap());
        issue_event(abs_event(2'd0, tsr_pkg::CODE_WINDOW, 32'hFFFF_FFFF), next_gap());
        issue_event(abs_event(2'd0, tsr_pkg::CODE_WINDOW, 32'h8000_0000), next_gap());
        issue_event(abs_event(2'd3, tsr_pkg::CODE_SLOT, 32'h7FFF_FFFF), next_gap());
        issue_event(abs_event(2'd3, tsr_pkg::CODE_TRACK_ID, 32'hFFFF_FFFF), next_gap());
        issue_event(abs_event(2'd0, tsr_pkg::CODE_SLOT, 32'd0), next_gap());
        issue_event(abs_event(2'd0, CODE_POS_Y, 32'h8000_0000), next_gap());
        issue_event(abs_event(2'd2, 16'hFFFF, 32'd1), next_gap());
    endtask

    // Fills the slot table, drives requests into the full case, then frees a few entries.
    task automatic test_table_full();
        int          full_prev;
        int          k;
        logic [31:0] owned[$];
        wait_idle();
        k = 0;
        do
        begin
            full_prev = n_full;
            issue_event(abs_event(2'd3, tsr_pkg::CODE_SLOT, 32'h0001_0000 + k), next_gap());
            k++;
        end
        while (n_full == full_prev);

        issue_event(abs_event(2'd3, CODE_POS_X, 32'd9), next_gap());
        issue_event(abs_event(2'd3, tsr_pkg::CODE_TRACK_ID, 32'hFFFF_FFFF), next_gap());
        issue_event(abs_event(2'd3, tsr_pkg::CODE_WINDOW, 32'd5), next_gap());
        issue_event(abs_event(2'd0, CODE_POS_X, 32'd1), next_gap());
        issue_event(make_req(2'd3, 1'b0, tsr_pkg::TYPE_ABS, CODE_POS_X, 32'd2), next_gap());

        for (int i = 0; i < SLOTS; i++)
            if (slot_used[i] && slot_owner[i] == 2'd3)
                owned.push_back(slot_hslot[i]);
        for (int i = 0; i < owned.size() && i < 4; i++)
        begin
            issue_event(abs_event(2'd3, tsr_pkg::CODE_SLOT, owned[i]), next_gap());
            issue_event(abs_event(2'd3, tsr_pkg::CODE_TRACK_ID, 32'hFFFF_FFFF), next_gap());
        end

        // A new pair takes one of the freed entries.
        issue_event(abs_event(2'd1, tsr_pkg::CODE_SLOT, 32'h0002_0000), next_gap());
    endtask

    // Mostly well-formed touch sequences with random content, the rest noise.
    task automatic test_random(input int count);
        int                         sent;
        bit                         paused;
        logic [tsr_pkg::HOST_W-1:0] host;
        logic [31:0]                hslot;
        logic [15:0]                code;
        logic [31:0]                value;
        sent = 0;
        paused = 1'b0;
        while (sent < count)
        begin
            burst_mode = ($urandom_range(0, 3) == 0);
            if ($urandom_range(0, 3) != 0)
            begin
                host  = tsr_pkg::HOST_W'($urandom_range(0, HOSTS - 1));
                hslot = ($urandom_range(0, 7) == 0) ? $urandom : $urandom_range(0, 7);
                if ($urandom_range(0, 7) != 0)
                begin
                    issue_event(abs_event(host, tsr_pkg::CODE_SLOT, hslot), next_gap());
                    sent++;
                end
                repeat ($urandom_range(1, 4))
                begin
                    value = $urandom;
                    case ($urandom_range(0, 5))
                        0: code = CODE_POS_X;
                        1: code = CODE_POS_Y;
                        2: code = CODE_PRESSURE;
                        3:
                        begin
                            code = tsr_pkg::CODE_TRACK_ID;
                            if ($urandom_range(0, 2) == 0)
                                value = 32'hFFFF_FFFF;
                        end
                        4:
                        begin
                            code = tsr_pkg::CODE_WINDOW;
                            if ($urandom_range(0, 3) != 0)
                                value = $urandom_range(0, 3);
                        end
                        default:
                        begin
                            code  = tsr_pkg::CODE_TRACK_ID;
                            value = 32'hFFFF_FFFF;
                        end
                    endcase
                    issue_event(abs_event(host, code, value), next_gap());
                    sent++;
                end
            end
            else
            begin
                issue_event(make_req(tsr_pkg::HOST_W'($urandom_range(0, 3)),
                                     1'($urandom_range(0, 1)),
                                     $urandom_range(0, 1) ? tsr_pkg::TYPE_ABS : 16'($urandom),
                                     16'($urandom), $urandom), next_gap());
                sent++;
            end
            if (!paused && sent >= count / 2)
            begin
                wait_idle();
                paused = 1'b1;
            end
        end
        burst_mode = 1'b0;
    endtask

    initial
    begin
        rst_n = 1'b0;
        start = 1'b0;
        req   = '0;
        for (int i = 0; i < SLOTS; i++)
        begin
            slot_used[i]  = 1'b0;
            slot_owner[i] = '0;
            slot_hslot[i] = '0;
        end
        for (int i = 0; i < HOSTS; i++)
        begin
            host_slot_now[i] = '0;
            host_win[i]      = '0;
        end
        win_now      = '0;
        out_slot_now = 0;
        track_next   = '0;
        n_items      = 0;
        n_results    = 0;
        n_full       = 0;
        n_inserted   = 0;
        n_errors     = 0;
        burst_mode   = 1'b0;

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_passthrough();
        test_track_counter();
        test_window_slot();
        test_random(70);
        test_table_full();

        // Drain everything still owed, then give the block time to show strays.
        wait_idle();
        repeat (2 * SLOTS + 8) @(posedge clk);
        if (pending_events.size() != 0)
        begin
            $display("%0d expected events never came out", pending_events.size());
            n_errors += pending_events.size();
        end

        $display("Sent %0d requests and checked %0d output events, %0d of them inserted.",
                 n_items, n_results, n_inserted);
        $display("Covered tracking id renumbering, slot reuse and %0d requests on a full table.",
                 n_full);
        if (n_errors == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

// File: touch_slot_remapper_unit.f
sv/tsr_pkg.sv
sv/tsr_front.sv
sv/tsr_queue.sv
sv/tsr_back.sv
sv/touch_slot_remapper_unit.sv
dv/touch_slot_remapper_unit_tb.sv
